/* hdl/sts_pkg.sv */
`default_nettype none

package sts_pkg;

  // token codes of one result
  typedef enum logic [2:0] {
    TokEof     = 3'd0,
    TokNewline = 3'd1,
    TokCall    = 3'd2,
    TokIdent   = 3'd3,
    TokOp      = 3'd4,
    TokError   = 3'd5
  } token_e;

  typedef struct packed {
    token_e      token;
    logic [7:0]  op_char;
    logic [15:0] start_pos;
    logic [15:0] length;
    logic        last;
  } result_t;

  // most results one input request can cause
  localparam int MaxResults = 3;

  // results handed from the scanner to the output queue in one cycle
  typedef struct packed {
    logic [1:0]                   count;
    result_t [MaxResults-1:0]     res;
  } push_t;

  // character codes
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChQuote     = 8'h27;
  localparam logic [7:0] ChUnder     = 8'h5F;
  localparam logic [7:0] ChLParen    = 8'h28;
  localparam logic [7:0] ChRParen    = 8'h29;
  localparam logic [7:0] ChComma     = 8'h2C;
  localparam logic [7:0] ChEqual     = 8'h3D;
  localparam logic [7:0] ChPlus      = 8'h2B;
  localparam logic [7:0] ChMinus     = 8'h2D;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChCaret     = 8'h5E;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDot       = 8'h2E;

  // keyword text, lower case
  localparam logic [7:0] KwText [4] = '{8'h63, 8'h61, 8'h6C, 8'h6C};
  localparam logic [2:0] KwLen  = 3'd4;
  localparam logic [2:0] KwFail = 3'd7;

endpackage

`default_nettype wire

/* hdl/script_token_scanner_top.sv */
// Script token scanner: one character request in, a stream of token results out.
// Input channel: in_valid_i / in_stall_o with kind_i (0 character, 1 end of
// script) and char_code_i. Output channel: out_valid_o / out_stall_i with
// token_o, op_char_o, start_pos_o, length_o and last_o; last_o marks the final
// result caused by one input request.
// The results of a request are registered into the result queue when it is taken.
// Throughput: one request per cycle while each request yields at most one
// result and the receiver does not stall; a request that yields two or three
// results (word flush, newline, eof) sends them out one at a time. The
// four-entry result queue takes a request whenever at most one result is
// waiting, so the input keeps moving while a result is held.
// Receiver stall: results stay at the queue head unchanged; once two or more
// results wait, in_stall_o rises until at most one result waits.
// Reset: the queue empties, the scanner goes idle with position zero and
// the newline flag set. After an unknown character the scanner halts: requests
// are still taken but yield nothing until reset. End of script returns all
// scan state to its reset values.
`default_nettype none

module script_token_scanner_top #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  char_code_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       token_o,
  output logic [7:0]       op_char_o,
  output logic [15:0]      start_pos_o,
  output logic [15:0]      length_o,
  output logic             last_o
);
  import sts_pkg::*;

  push_t   push;
  result_t head;
  logic    full;
  logic    in_fire;
  logic    pop;

  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !full;
  assign pop        = out_valid_o && !out_stall_i;

  // classification and scan state
  sts_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .kind_i     (kind_i),
    .char_code_i(char_code_i),
    .push_o     (push)
  );

  // result queue
  sts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .valid_o(out_valid_o),
    .full_o (full)
  );

  assign token_o     = head.token;
  assign op_char_o   = head.op_char;
  assign start_pos_o = head.start_pos;
  assign length_o    = head.length;
  assign last_o      = head.last;

endmodule

`default_nettype wire

/* hdl/sts_scan.sv */
`default_nettype none

module sts_scan #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire logic          kind_i,
  input  wire logic [7:0]    char_code_i,
  output sts_pkg::push_t     push_o
);
  import sts_pkg::*;

  localparam logic [1:0] ModeIdle    = 2'd0;
  localparam logic [1:0] ModeWord    = 2'd1;
  localparam logic [1:0] ModeComment = 2'd2;
  localparam logic [1:0] ModeHalt    = 2'd3;

  localparam int SatBits = (POSITION_BITS > 16) ? POSITION_BITS : 16;

  logic [1:0]               mode_q, mode_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] ws_q, ws_d;
  logic [15:0]              wl_q, wl_d;
  logic [2:0]               kw_q, kw_d;
  logic                     lwn_q, lwn_d;

  logic [SatBits-1:0]       ws_ext;
  logic [15:0]              start16;

  function automatic logic [2:0] kw_next(logic [2:0] kw, logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    if (kw < KwLen && lc == KwText[kw[1:0]]) return kw + 3'd1;
    return KwFail;
  endfunction

  function automatic result_t mk(token_e tok, logic [7:0] ch, logic [15:0] st,
                                 logic [15:0] len);
    result_t r;
    r.token     = tok;
    r.op_char   = ch;
    r.start_pos = st;
    r.length    = len;
    r.last      = 1'b0;
    return r;
  endfunction

  // character classes
  logic c_letter, c_word, c_op, c_blank;
  always_comb begin
    c_letter = (char_code_i >= 8'h61 && char_code_i <= 8'h7A) ||
               (char_code_i >= 8'h41 && char_code_i <= 8'h5A);
    c_word   = c_letter || (char_code_i >= 8'h30 && char_code_i <= 8'h39) ||
               char_code_i == ChUnder;
    c_op     = char_code_i == ChLParen || char_code_i == ChRParen ||
               char_code_i == ChComma || char_code_i == ChEqual ||
               char_code_i == ChPlus || char_code_i == ChMinus ||
               char_code_i == ChStar || char_code_i == ChSlash ||
               char_code_i == ChCaret || char_code_i == ChBackslash ||
               char_code_i == ChDot;
    c_blank  = char_code_i == ChSpace || char_code_i == ChTab || char_code_i == ChCr;
  end

  // saturated start offset of the pending word
  always_comb begin
    ws_ext  = SatBits'(ws_q);
    start16 = (ws_ext > SatBits'(17'h0FFFF)) ? 16'hFFFF : ws_ext[15:0];
  end

  // next state and up to three results in order
  logic    a_v, b_v, e_v, lwn_a;
  result_t a_r, b_r, e_r, flush_r;
  logic [1:0] idx;
  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    ws_d   = ws_q;
    wl_d   = wl_q;
    kw_d   = kw_q;
    lwn_d  = lwn_q;
    a_v = 1'b0; b_v = 1'b0; e_v = 1'b0;
    a_r = '0;   b_r = '0;   e_r = '0;
    lwn_a = lwn_q;
    flush_r = mk((kw_q == KwLen) ? TokCall : TokIdent, 8'h00, start16, wl_q);

    if (fire_i && mode_q != ModeHalt) begin
      if (!kind_i) begin
        if (~&pos_q) pos_d = pos_q + 1'b1;
        if (mode_q == ModeComment) begin
          if (char_code_i == ChLf) begin
            mode_d = ModeIdle;
            if (!lwn_q) begin
              a_v = 1'b1;
              a_r = mk(TokNewline, 8'h00, 16'h0000, 16'h0000);
              lwn_d = 1'b1;
            end
          end
        end else if (mode_q == ModeWord && c_word) begin
          if (~&wl_q) wl_d = wl_q + 16'd1;
          kw_d = kw_next(kw_q, char_code_i);
        end else begin
          // close a pending word first
          if (mode_q == ModeWord) begin
            a_v    = 1'b1;
            a_r    = flush_r;
            mode_d = ModeIdle;
            lwn_a  = 1'b0;
          end
          lwn_d = lwn_a;
          if (c_blank) begin
            // skipped
          end else if (c_letter) begin
            mode_d = ModeWord;
            ws_d   = pos_q;
            wl_d   = 16'd1;
            kw_d   = kw_next(3'd0, char_code_i);
          end else if (char_code_i == ChLf) begin
            if (!lwn_a) begin
              b_v   = 1'b1;
              b_r   = mk(TokNewline, 8'h00, 16'h0000, 16'h0000);
              lwn_d = 1'b1;
            end
          end else if (char_code_i == ChQuote) begin
            mode_d = ModeComment;
          end else if (c_op) begin
            b_v   = 1'b1;
            b_r   = mk(TokOp, char_code_i, 16'h0000, 16'h0000);
            lwn_d = 1'b0;
          end else begin
            b_v    = 1'b1;
            b_r    = mk(TokError, char_code_i, 16'h0000, 16'h0000);
            lwn_d  = 1'b0;
            mode_d = ModeHalt;
          end
        end
      end else begin
        // end of script: flush, newline, eof, then back to reset state
        if (mode_q == ModeWord) begin
          a_v   = 1'b1;
          a_r   = flush_r;
          lwn_a = 1'b0;
        end else if (mode_q == ModeComment && !lwn_q) begin
          a_v   = 1'b1;
          a_r   = mk(TokNewline, 8'h00, 16'h0000, 16'h0000);
          lwn_a = 1'b1;
        end
        if (!lwn_a) begin
          b_v = 1'b1;
          b_r = mk(TokNewline, 8'h00, 16'h0000, 16'h0000);
        end
        e_v    = 1'b1;
        e_r    = mk(TokEof, 8'h00, 16'h0000, 16'h0000);
        mode_d = ModeIdle;
        pos_d  = '0;
        ws_d   = '0;
        wl_d   = '0;
        kw_d   = '0;
        lwn_d  = 1'b1;
      end
    end

    // pack the results without gaps and mark the final one
    push_o = '0;
    idx    = 2'd0;
    if (a_v) begin
      push_o.res[idx] = a_r;
      idx = idx + 2'd1;
    end
    if (b_v) begin
      push_o.res[idx] = b_r;
      idx = idx + 2'd1;
    end
    if (e_v) begin
      push_o.res[idx] = e_r;
      idx = idx + 2'd1;
    end
    if (idx != 2'd0) push_o.res[idx - 2'd1].last = 1'b1;
    push_o.count = idx;
  end

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      pos_q  <= '0;
      ws_q   <= '0;
      wl_q   <= '0;
      kw_q   <= '0;
      lwn_q  <= 1'b1;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      ws_q   <= ws_d;
      wl_q   <= wl_d;
      kw_q   <= kw_d;
      lwn_q  <= lwn_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/sts_queue.sv */
`default_nettype none

module sts_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sts_pkg::push_t  push_i,
  input  wire logic            pop_i,
  output sts_pkg::result_t     head_o,
  output logic                 valid_o,
  output logic                 full_o
);
  import sts_pkg::*;

  localparam int Depth = MaxResults + 1;

  result_t    q_q [Depth];
  result_t    q_d [Depth];
  result_t    sh  [Depth];
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] base;

  // shift out the head on a taken result, then append new results
  always_comb begin
    for (int i = 0; i < Depth - 1; i++) begin
      sh[i] = pop_i ? q_q[i+1] : q_q[i];
    end
    sh[Depth-1] = q_q[Depth-1];
    base = cnt_q - {2'b00, pop_i};
    for (int j = 0; j < Depth; j++) begin
      q_d[j] = sh[j];
      for (int k = 0; k < MaxResults; k++) begin
        if (2'(k) < push_i.count && base + 3'(k) == 3'(j)) q_d[j] = push_i.res[k];
      end
    end
    cnt_d = base + {1'b0, push_i.count};
  end

  assign head_o  = q_q[0];
  assign valid_o = cnt_q != 3'd0;
  // room for a full burst only while at most one result waits
  assign full_o  = cnt_q > 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < Depth; j++) begin
      q_q[j] <= q_d[j];
    end
  end

endmodule

`default_nettype wire
